// ===== rtl/linear_probe_hash_table_unit_assert.svh =====
// Assertion macros for the linear-probe hash table unit.
// Used by the top level; relies on clk and rst being in scope where expanded.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/lpht_pkg.sv =====
// Shared types, codes and constants for the linear-probe hash table unit.
// No dependencies; used by the controller, the datapath and the top level.
package lpht_pkg;

  localparam int SLOTS     = 26;
  localparam int SLOT_W    = 5;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;

  // Only the top KEY_BYTES bytes of a key take part in the comparison.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));

  localparam logic [7:0] CHAR_LOW  = 8'd97;
  localparam logic [7:0] CHAR_HIGH = 8'd122;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_CAP  = SLOT_W'(SLOTS);

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ABSENT      = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_BAD_INITIAL = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  found_value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       advance;
    logic       finish;
    logic [1:0] status;
    logic       write_slot;
    logic       clear_slot;
    logic       read_value;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       bad_initial;
    logic       full;
    logic       hit;
    logic       last;
  } dp_stat_t;

endpackage

// ===== rtl/lpht_ctrl.sv =====
// Probe sequencer for the linear-probe hash table unit.
// Depends on lpht_pkg for the command, status and handshake structs.
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lpht_pkg::dp_stat_t stat,
  output lpht_pkg::ctl_t     ctl,
  output logic               busy,
  output logic               done
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic state;
  logic state_next;
  logic done_next;

  // Next-state and command decode.
  always_comb begin
    ctl        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ctl.finish = 1'b1;
        if (stat.command == lpht_pkg::CMD_INSERT && stat.full) begin
          ctl.status = lpht_pkg::ST_FULL;
        end else if (stat.command != lpht_pkg::CMD_INSERT &&
                     stat.command != lpht_pkg::CMD_FIND &&
                     stat.command != lpht_pkg::CMD_DELETE) begin
          ctl.status = lpht_pkg::ST_ABSENT;
        end else if (stat.bad_initial) begin
          ctl.status = lpht_pkg::ST_BAD_INITIAL;
        end else if (stat.hit) begin
          ctl.status     = lpht_pkg::ST_OK;
          ctl.write_slot = (stat.command == lpht_pkg::CMD_INSERT);
          ctl.read_value = (stat.command == lpht_pkg::CMD_FIND);
          ctl.clear_slot = (stat.command == lpht_pkg::CMD_DELETE);
        end else if (stat.last) begin
          ctl.status = (stat.command == lpht_pkg::CMD_INSERT) ?
                       lpht_pkg::ST_FULL : lpht_pkg::ST_ABSENT;
        end else begin
          ctl.finish  = 1'b0;
          ctl.advance = 1'b1;
        end
        if (ctl.finish) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state == ST_PROBE);

endmodule

// ===== rtl/lpht_dp.sv =====
// Datapath of the linear-probe hash table unit: slot storage, probe pointer,
// occupancy count and result register. Depends on lpht_pkg.
module lpht_dp (
  input  logic               clk,
  input  logic               rst,
  input  lpht_pkg::req_t     request,
  input  lpht_pkg::ctl_t     ctl,
  output lpht_pkg::dp_stat_t stat,
  output lpht_pkg::rsp_t     result
);

  logic [lpht_pkg::SLOTS-1:0]  slot_used;
  logic [lpht_pkg::KEY_W-1:0]  key_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::VAL_W-1:0]  value_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::SLOT_W-1:0] occupancy;

  logic [1:0]                  cmd;
  logic [lpht_pkg::KEY_W-1:0]  key;
  logic [lpht_pkg::VAL_W-1:0]  value;
  logic                        bad_initial;
  logic [lpht_pkg::SLOT_W-1:0] ptr;
  logic [lpht_pkg::SLOT_W-1:0] ptr_next;
  logic [lpht_pkg::SLOT_W-1:0] cnt;
  logic [lpht_pkg::KEY_W-1:0]  key_rd;

  logic [7:0]                  req_initial;
  logic [7:0]                  req_home;
  logic                        key_equal;

  // Home slot and initial check of an incoming beat.
  assign req_initial = request.lookup_key[lpht_pkg::KEY_W-1 -: 8];
  assign req_home    = req_initial - lpht_pkg::CHAR_LOW;

  // Comparison against the stored key of the slot under the probe pointer.
  assign key_equal = (key_rd == key);

  always_comb begin
    stat.command     = cmd;
    stat.bad_initial = bad_initial;
    stat.full        = (occupancy >= lpht_pkg::SLOT_CAP);
    stat.hit         = (cmd == lpht_pkg::CMD_INSERT) ? !slot_used[ptr] :
                       (slot_used[ptr] && key_equal);
    stat.last        = (cnt == lpht_pkg::SLOT_LAST);
  end

  // Next probe pointer: the home slot on a new beat, then one step around the ring.
  always_comb begin
    ptr_next = ptr;
    if (ctl.load) begin
      ptr_next = req_home[lpht_pkg::SLOT_W-1:0];
    end else if (ctl.advance) begin
      ptr_next = (ptr == lpht_pkg::SLOT_LAST) ? '0 : ptr + 1'b1;
    end
  end

  // Request capture and probe pointer walk.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd         <= request.command;
      key         <= request.lookup_key & lpht_pkg::KEY_MASK;
      value       <= request.entry_value;
      bad_initial <= (req_initial < lpht_pkg::CHAR_LOW) ||
                     (req_initial > lpht_pkg::CHAR_HIGH);
    end
    ptr <= ptr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Slot valid bits and occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      occupancy <= '0;
    end else if (ctl.write_slot) begin
      slot_used[ptr] <= 1'b1;
      occupancy      <= occupancy + 1'b1;
    end else if (ctl.clear_slot) begin
      slot_used[ptr] <= 1'b0;
      if (occupancy != '0) begin
        occupancy <= occupancy - 1'b1;
      end
    end
  end

  // Key and value storage, written on a successful insert. The key of the next
  // probed slot is read alongside the pointer update, so it lines up with ptr.
  always_ff @(posedge clk) begin
    if (ctl.write_slot) begin
      key_mem[ptr]   <= key;
      value_mem[ptr] <= value;
    end
    key_rd <= key_mem[ptr_next];
  end

  // Result register, loaded when a probe sequence ends.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.status      <= ctl.status;
      result.slot        <= (ctl.status == lpht_pkg::ST_OK) ? ptr : '0;
      result.found_value <= ctl.read_value ? value_mem[ptr] : '0;
    end
  end

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
// Top level of the linear-probe hash table unit: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp and the assertion macro header.
//
// A command beat is taken when start is high and busy is low. The unit then
// walks the 26 slots from the key's home slot, one slot per cycle, and stops
// at the first free slot (insert) or the first equal key (find, delete);
// rejected commands stop in the first probe cycle. Result and done are
// registered as the last probe cycle ends, so the unit works on one command
// at a time, its cost set by the single-slot probe loop. The result is on
// the result port for exactly one cycle with done high and cannot be held
// off; busy is already low in that cycle, so the next command may be taken
// at once.
`include "linear_probe_hash_table_unit_assert.svh"

module linear_probe_hash_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lpht_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output lpht_pkg::rsp_t result
);

  lpht_pkg::ctl_t     ctl;
  lpht_pkg::dp_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  lpht_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .stat    (stat),
    .result  (result)
  );

  // A taken beat always starts a probe sequence.
  `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  // The result strobe ends the probe sequence.
  `LPHT_ASSERT_NOW(a_done_idle, done, !busy && $past(busy))
  // A failed command reports no slot and no value.
  `LPHT_ASSERT_NOW(a_fail_clean, done && result.status != lpht_pkg::ST_OK,
                   result.slot == '0 && result.found_value == '0)

endmodule

// ===== tb/hash_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the linear-probe hash table unit: it keeps a shadow copy of the table,
// predicts each result beat and compares it field by field. Depends on lpht_pkg.
module hash_table_checker
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic done,
  input  rsp_t result,
  output int   fail_count,
  output int   pending_count,
  output int   result_count,
  output int   full_count
);

  logic             slot_taken [SLOTS];
  logic [KEY_W-1:0] slot_name  [SLOTS];
  logic [VAL_W-1:0] slot_data  [SLOTS];
  int               fill;
  int               fails   = 0;
  int               results = 0;
  int               fulls   = 0;
  rsp_t             awaited_results [$];

  // Applies one command beat to the shadow table and returns the result it should give.
  function automatic rsp_t apply_command(req_t cmd);
    rsp_t             rsp;
    logic [KEY_W-1:0] name;
    logic [7:0]       lead;
    int               home;
    int               s;
    int               hit;
    rsp = '0;
    rsp.status = ST_ABSENT;
    name = cmd.lookup_key & KEY_MASK;
    lead = name[KEY_W-1 -: 8];
    home = (lead >= CHAR_LOW && lead <= CHAR_HIGH) ? int'(lead - CHAR_LOW) : -1;
    case (cmd.command)
      CMD_INSERT: begin
        // A full table is reported before the initial is looked at.
        if (fill >= SLOTS) begin
          rsp.status = ST_FULL;
        end else if (home < 0) begin
          rsp.status = ST_BAD_INITIAL;
        end else begin
          rsp.status = ST_FULL;
          for (int k = 0; k < SLOTS && rsp.status == ST_FULL; k++) begin
            s = (home + k) % SLOTS;
            if (!slot_taken[s]) begin
              slot_taken[s] = 1'b1;
              slot_name[s]  = name;
              slot_data[s]  = cmd.entry_value;
              fill++;
              rsp.status = ST_OK;
              rsp.slot   = SLOT_W'(s);
            end
          end
        end
      end
      CMD_FIND, CMD_DELETE: begin
        if (home < 0) begin
          rsp.status = ST_BAD_INITIAL;
        end else begin
          // Walk the whole ring from home; free slots do not stop the search.
          hit = -1;
          for (int k = 0; k < SLOTS && hit < 0; k++) begin
            s = (home + k) % SLOTS;
            if (slot_taken[s] && slot_name[s] == name) hit = s;
          end
          if (hit >= 0) begin
            rsp.status = ST_OK;
            rsp.slot   = SLOT_W'(hit);
            if (cmd.command == CMD_FIND) begin
              rsp.found_value = slot_data[hit];
            end else begin
              slot_taken[hit] = 1'b0;
              if (fill > 0) fill--;
            end
          end
        end
      end
      default: begin
        // The spare command code leaves the table alone and reports not present.
      end
    endcase
    return rsp;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fails++;
    end
  endtask

  // Sample both channels at the rising edge; results are checked before a new
  // command beat is predicted, since no result can belong to that beat.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
      fill = 0;
      awaited_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                   $time, result);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          results++;
          if (want.status == ST_FULL) fulls++;
          compare_field("status", 64'(want.status), 64'(result.status));
          compare_field("slot", 64'(want.slot), 64'(result.slot));
          compare_field("found_value", want.found_value, result.found_value);
        end
      end
      if (start === 1'b1 && busy === 1'b0) awaited_results.push_back(apply_command(request));
    end
    fail_count    <= fails;
    pending_count <= awaited_results.size();
    result_count  <= results;
    full_count    <= fulls;
  end

endmodule

// ===== tb/linear_probe_hash_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the linear-probe hash table unit: clock, reset, command stimulus
// and the verdict. Depends on lpht_pkg, the unit itself and hash_table_checker.
module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES       = 4;
  localparam int POOL_SIZE    = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst     = 1'b1;
  logic start   = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  int fail_count;
  int pending_count;
  int result_count;
  int full_count;
  int cycle_count = 0;
  int sent        = 0;
  int idle_pct    = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  linear_probe_hash_table_unit uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  hash_table_checker table_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .full_count    (full_count)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t make_cmd(logic [1:0] op, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] value);
    req_t cmd;
    cmd.command     = op;
    cmd.lookup_key  = key;
    cmd.entry_value = value;
    return cmd;
  endfunction

  // Packs a short name into a key, first character in the top byte.
  function automatic logic [KEY_W-1:0] pack_name(string text);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int i = 0; i < text.len() && i < KEY_BYTES; i++) key[KEY_W-1-8*i -: 8] = text[i];
    return key;
  endfunction

  // A name of one to eight bytes with the given initial; tails are mostly letters.
  function automatic logic [KEY_W-1:0] random_name(logic [7:0] lead);
    logic [KEY_W-1:0] key;
    int               len;
    key = '0;
    key[KEY_W-1 -: 8] = lead;
    len = $urandom_range(KEY_BYTES, 1);
    for (int i = 1; i < len; i++)
      key[KEY_W-1-8*i -: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(CHAR_HIGH, CHAR_LOW));
    return key;
  endfunction

  function automatic logic [7:0] random_bad_lead();
    logic [7:0] b;
    case ($urandom_range(3))
      0: b = CHAR_LOW - 8'd1;
      1: b = CHAR_HIGH + 8'd1;
      default: begin
        do b = 8'($urandom_range(255)); while (b >= CHAR_LOW && b <= CHAR_HIGH);
      end
    endcase
    return b;
  endfunction

  // Mostly pool keys so that finds and deletes hit; a few fresh names, bad initials,
  // spare command codes and fully random beats mixed in.
  function automatic req_t random_cmd(int insert_pct);
    int               roll;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    roll  = $urandom_range(99);
    value = {$urandom, $urandom};
    if ($urandom_range(99) < insert_pct) op = CMD_INSERT;
    else op = $urandom_range(1) ? CMD_FIND : CMD_DELETE;
    if ($urandom_range(9) == 0) key = random_name(8'($urandom_range(CHAR_HIGH, CHAR_LOW)));
    else key = key_pool[$urandom_range(POOL_SIZE - 1)];
    if (roll < 3) begin
      op  = 2'($urandom_range(3));
      key = {$urandom, $urandom};
    end else if (roll < 6) begin
      op = CMD_UNUSED;
    end else if (roll < 10) begin
      key[KEY_W-1 -: 8] = random_bad_lead();
    end
    return make_cmd(op, key, value);
  endfunction

  // Drives one command beat from a falling edge and holds it until it is taken.
  task automatic issue(input req_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= cmd;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    int         insert_pct;
    logic [7:0] lead;

    // Key pool clustered on a few initials, so probes collide and wrap past the end.
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(9))
        0, 1:    lead = CHAR_LOW;
        2, 3:    lead = CHAR_HIGH;
        4:       lead = CHAR_LOW + 8'd1;
        5:       lead = CHAR_HIGH - 8'd1;
        6:       lead = CHAR_LOW + 8'd12;
        default: lead = 8'($urandom_range(CHAR_HIGH, CHAR_LOW));
      endcase
      key_pool[i] = random_name(lead);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, wrap from the last slot, duplicates, bad initials,
    // the spare command code and extreme keys and values.
    issue(make_cmd(CMD_FIND, pack_name("a"), '1));
    issue(make_cmd(CMD_DELETE, pack_name("a"), '0));
    issue(make_cmd(CMD_INSERT, pack_name("a"), '0));
    issue(make_cmd(CMD_INSERT, pack_name("z"), '1));
    issue(make_cmd(CMD_INSERT, pack_name("z"), 64'd1));
    issue(make_cmd(CMD_FIND, pack_name("z"), '0));
    issue(make_cmd(CMD_DELETE, pack_name("z"), '0));
    issue(make_cmd(CMD_FIND, pack_name("z"), '0));
    issue(make_cmd(CMD_INSERT, 64'h6061_0000_0000_0000, 64'h1234_5678_9abc_def0));
    issue(make_cmd(CMD_INSERT, 64'h7b7a_0000_0000_0000, '1));
    issue(make_cmd(CMD_FIND, '0, '0));
    issue(make_cmd(CMD_DELETE, '1, '1));
    issue(make_cmd(CMD_UNUSED, pack_name("a"), '1));
    issue(make_cmd(CMD_INSERT, 64'h61ff_ffff_ffff_ffff, 64'h8000_0000_0000_0001));
    issue(make_cmd(CMD_FIND, 64'h61ff_ffff_ffff_ffff, '0));
    issue(make_cmd(CMD_FIND, pack_name("ab"), '0));
    issue(make_cmd(CMD_INSERT, pack_name("mmmmmmmm"), 64'h5555_aaaa_5555_aaaa));
    issue(make_cmd(CMD_FIND, pack_name("mmmmmmmm"), '0));
    issue(make_cmd(CMD_DELETE, pack_name("a"), '0));
    issue(make_cmd(CMD_INSERT, pack_name("b"), 64'haaaa_5555_aaaa_5555));
    issue(make_cmd(CMD_FIND, pack_name("a"), '0));

    // Random: per pacing phase, alternate fill-heavy and drain-heavy stretches so the
    // table runs full and empties again many times.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       idle_pct = 85;
        2:       idle_pct = 25;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        insert_pct = ((n / 60) % 2 == 0) ? 75 : 15;
        issue(random_cmd(insert_pct));
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command beats over four pacing phases; %0d result beats checked,",
             sent, result_count);
    $display("%0d of them table-full rejections.", full_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
